FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define BTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bts: assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define BTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bts: assertion failed");
`else
`define BTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BTS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/bts_pkg.sv
`default_nettype none

package bts_pkg;

   // Fixed-point format of coordinates, weights and blended values.
   localparam int FRAC_BITS = 16;
   localparam int WGT_W     = FRAC_BITS + 1;
   localparam logic [WGT_W-1:0] ONE_FX = WGT_W'(1) << FRAC_BITS;

   // Texture geometry and store.
   localparam int MAX_DIM     = 256;
   localparam int DIM_W       = 9;
   localparam int COORD_W     = 8;
   localparam int TEXEL_DEPTH = 65536;
   localparam int ADDR_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int TEXEL_W     = 3 * BYTE_W;
   localparam int CNT_W       = 3;
   localparam int FIX_W       = 32;
   localparam int OUT_W       = 24;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Item actions.
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // Color channels and the four neighbors of a sample.
   localparam int CH_COUNT = 3;
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam int Q00 = 0;  // column x0, row y0
   localparam int Q10 = 1;  // column x1, row y0
   localparam int Q01 = 2;  // column x0, row y1
   localparam int Q11 = 3;  // column x1, row y1

   // Result of a sample on an empty texture: 255.0 in 8.16.
   localparam logic [OUT_W-1:0] WHITE_FX = OUT_W'(255) << FRAC_BITS;

   typedef logic [3:0][TEXEL_W-1:0] texel_quad_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [TEXEL_W-1:0]  data;
   } st_wr_type;

   typedef struct packed {
      logic                   en;
      logic [3:0][ADDR_W-1:0] addr;
   } st_rd_type;

   // One channel of a texel; missing channels copy channel 0.
   function automatic logic [BYTE_W-1:0] texel_chan(input logic [TEXEL_W-1:0] t,
                                                    input logic [1:0] ch,
                                                    input logic [CNT_W-1:0] cnt);
      logic [BYTE_W-1:0] res;
      res = t[BYTE_W-1:0];
      if (ch == CH_GREEN && cnt > 3'd1) begin
         res = t[2*BYTE_W-1:BYTE_W];
      end else if (ch == CH_BLUE && cnt > 3'd2) begin
         res = t[3*BYTE_W-1:2*BYTE_W];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bts_req_if.sv
`default_nettype none

// Request channel: texel writes and sample requests.
interface bts_req_if;
   import bts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [ADDR_W-1:0]         texel_index;
   logic [BYTE_W-1:0]         byte_zero;
   logic [BYTE_W-1:0]         byte_one;
   logic [BYTE_W-1:0]         byte_two;
   logic signed [FIX_W-1:0]   u_coord;
   logic signed [FIX_W-1:0]   v_coord;

   modport source (output valid, action, texel_index, byte_zero, byte_one, byte_two,
                   u_coord, v_coord, input ready);
   modport sink   (input valid, action, texel_index, byte_zero, byte_one, byte_two,
                   u_coord, v_coord, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bts_rsp_if.sv
`default_nettype none

// Response channel: one filtered RGB color per sample.
interface bts_rsp_if;
   import bts_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] red_out;
   logic [OUT_W-1:0] green_out;
   logic [OUT_W-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bts_texel_store.sv
`default_nettype none

// Texel store: two identical copies, each with one write port and two read
// ports. Every write goes to both copies; copy A serves the upper row of the
// neighborhood and copy B the lower row. Read data is registered.
module bts_texel_store (
   input  wire logic                    clock,
   input  wire bts_pkg::st_wr_type      wr,
   input  wire bts_pkg::st_rd_type      rd,
   output      bts_pkg::texel_quad_type quad
);
   import bts_pkg::*;

   logic [TEXEL_W-1:0] mem_a [TEXEL_DEPTH];
   logic [TEXEL_W-1:0] mem_b [TEXEL_DEPTH];
   texel_quad_type     quad_ff;

   // Write both copies.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_a[wr.addr] <= wr.data;
         mem_b[wr.addr] <= wr.data;
      end
   end

   // Read four neighbors, two from each copy; data holds while the read is off.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         quad_ff[Q00] <= mem_a[rd.addr[Q00]];
         quad_ff[Q10] <= mem_a[rd.addr[Q10]];
         quad_ff[Q01] <= mem_b[rd.addr[Q01]];
         quad_ff[Q11] <= mem_b[rd.addr[Q11]];
      end
   end

   assign quad = quad_ff;
endmodule

`default_nettype wire

FILE: hw/rtl/bilinear_texture_sampler.sv
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Transfer when          Carries
// req_ch    in         valid and ready high  action, texel_index, bytes, u_coord, v_coord
// rsp_ch    out        valid and ready high  red_out, green_out, blue_out
// csr       in         csr_we high           csr_idx, csr_wdata (no read-back)
//
// One item is taken per cycle unless a stalled response has filled the pipeline; a
// sample moves through the registered stages to the response register. The texel
// store's two copies each give two reads per cycle, so all four neighbors are fetched
// together; writes land in the same stage as the reads, so order holds. Reset is
// synchronous and clears the configuration registers and all stage valids, not the
// store. A stalled response holds the pipeline behind it stage by stage, and empty stages keep accepting.
module bilinear_texture_sampler (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bts_req_if.sink                         req_ch,
   bts_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_we,
   input  wire logic [bts_pkg::CSR_IDX_W-1:0] csr_idx,
   input  wire logic [bts_pkg::DIM_W-1:0]  csr_wdata
);
   import bts_pkg::*;

   localparam int X_W = FRAC_BITS + COORD_W;
   localparam int Y_W = WGT_W + COORD_W;
   localparam int H_W = OUT_W;
   localparam int P_W = H_W + WGT_W;

   // Configuration registers.
   logic [DIM_W-1:0] tex_width_ff;
   logic [DIM_W-1:0] tex_height_ff;
   logic [CNT_W-1:0] chan_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= '0;
         tex_height_ff <= '0;
         chan_cnt_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_TEX_WIDTH:     tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT:    tex_height_ff <= csr_wdata;
            CSR_CHANNEL_COUNT: chan_cnt_ff   <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective size, scales and last column and row.
   logic [DIM_W-1:0]   w_eff, h_eff, w_m1, h_m1;
   logic [COORD_W-1:0] sx, sy, last_col, last_row;
   logic               tex_empty;

   always_comb begin
      w_eff     = (tex_width_ff  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_width_ff;
      h_eff     = (tex_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_height_ff;
      w_m1      = w_eff - DIM_W'(1);
      h_m1      = h_eff - DIM_W'(1);
      last_col  = w_m1[COORD_W-1:0];
      last_row  = h_m1[COORD_W-1:0];
      sx        = (w_eff > DIM_W'(1)) ? last_col : COORD_W'(1);
      sy        = (h_eff > DIM_W'(1)) ? last_row : COORD_W'(1);
      tex_empty = (tex_width_ff == '0) || (tex_height_ff == '0) || (chan_cnt_ff == '0);
   end

   // Stage enables: a stage loads when it is empty or its item moves on.
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, rsp_vld_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !rsp_vld_ff || rsp_ch.ready;
   assign en5 = !s5_vld_ff || en6;
   assign en4 = !s4_vld_ff || en5;
   assign en3 = !s3_vld_ff || en4;
   assign en2 = !s2_vld_ff || en3;
   assign en1 = !s1_vld_ff || en2;

   assign req_ch.ready = en1;

   // Stage 1: capture the item, wrap coordinates to their fractions.
   logic                s1_smp_ff;
   logic [ADDR_W-1:0]   s1_idx_ff;
   logic [TEXEL_W-1:0]  s1_data_ff, s1_data_in;
   logic [FRAC_BITS-1:0] s1_fu_ff, s1_fu_in;
   logic [WGT_W-1:0]    s1_gv_ff, s1_gv_in;

   assign s1_data_in = {req_ch.byte_two, req_ch.byte_one, req_ch.byte_zero};
   assign s1_fu_in   = req_ch.u_coord[FRAC_BITS-1:0];
   assign s1_gv_in   = ONE_FX - {1'b0, req_ch.v_coord[FRAC_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en1) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_ch.valid) begin
         s1_smp_ff  <= (req_ch.action == ACT_SAMPLE);
         s1_idx_ff  <= req_ch.texel_index;
         s1_data_ff <= s1_data_in;
         s1_fu_ff   <= s1_fu_in;
         s1_gv_ff   <= s1_gv_in;
      end
   end

   // Stage 2: scale to texel positions.
   logic               s2_smp_ff;
   logic [ADDR_W-1:0]  s2_idx_ff;
   logic [TEXEL_W-1:0] s2_data_ff;
   logic [X_W-1:0]     s2_x_ff, s2_x_in;
   logic [Y_W-1:0]     s2_y_ff, s2_y_in;

   assign s2_x_in = X_W'(s1_fu_ff) * X_W'(sx);
   assign s2_y_in = Y_W'(s1_gv_ff) * Y_W'(sy);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en2) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_vld_ff) begin
         s2_smp_ff  <= s1_smp_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_data_ff <= s1_data_ff;
         s2_x_ff    <= s2_x_in;
         s2_y_ff    <= s2_y_in;
      end
   end

   // Stage 3: clamp neighbor indices at the edge and split off the weights.
   logic               s3_smp_ff;
   logic [ADDR_W-1:0]  s3_idx_ff;
   logic [TEXEL_W-1:0] s3_data_ff;
   logic [COORD_W-1:0] s3_x0_ff, s3_x1_ff, s3_y0_ff, s3_y1_ff;
   logic [COORD_W-1:0] s3_x0_in, s3_x1_in, s3_y0_in, s3_y1_in;
   logic [WGT_W-1:0]   s3_tx_ff, s3_ty_ff, s3_tx_in, s3_ty_in;
   logic [DIM_W-1:0]   y_int;
   logic [Y_W-1:0]     tx_full, ty_full;

   always_comb begin
      y_int    = s2_y_ff[Y_W-1:FRAC_BITS];
      s3_x0_in = (s2_x_ff[X_W-1:FRAC_BITS] > last_col) ? last_col
                                                       : s2_x_ff[X_W-1:FRAC_BITS];
      s3_y0_in = (y_int > {1'b0, last_row}) ? last_row : y_int[COORD_W-1:0];
      s3_x1_in = ({1'b0, s3_x0_in} + DIM_W'(1) > {1'b0, last_col}) ? last_col
                                                                : s3_x0_in + COORD_W'(1);
      s3_y1_in = ({1'b0, s3_y0_in} + DIM_W'(1) > {1'b0, last_row}) ? last_row
                                                                : s3_y0_in + COORD_W'(1);
      tx_full  = Y_W'(s2_x_ff) - (Y_W'(s3_x0_in) << FRAC_BITS);
      ty_full  = s2_y_ff - (Y_W'(s3_y0_in) << FRAC_BITS);
      s3_tx_in = (tx_full > Y_W'(ONE_FX)) ? ONE_FX : tx_full[WGT_W-1:0];
      s3_ty_in = (ty_full > Y_W'(ONE_FX)) ? ONE_FX : ty_full[WGT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en3) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_vld_ff) begin
         s3_smp_ff  <= s2_smp_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_data_ff <= s2_data_ff;
         s3_x0_ff   <= s3_x0_in;
         s3_x1_ff   <= s3_x1_in;
         s3_y0_ff   <= s3_y0_in;
         s3_y1_ff   <= s3_y1_in;
         s3_tx_ff   <= s3_tx_in;
         s3_ty_ff   <= s3_ty_in;
      end
   end

   // Stage 4: row addresses, then store write or four-texel read.
   localparam int RA_W = COORD_W + DIM_W;
   logic [RA_W-1:0]    row0_base, row1_base;
   st_wr_type          st_wr;
   st_rd_type          st_rd;
   texel_quad_type     quad;
   logic               s4_vld_in;
   logic [WGT_W-1:0]   s4_tx_ff, s4_ty_ff;

   always_comb begin
      row0_base = RA_W'(s3_y0_ff) * RA_W'(w_eff);
      row1_base = RA_W'(s3_y1_ff) * RA_W'(w_eff);
      st_wr.en   = en4 && s3_vld_ff && !s3_smp_ff;
      st_wr.addr = s3_idx_ff;
      st_wr.data = s3_data_ff;
      st_rd.en   = en4 && s3_vld_ff && s3_smp_ff;
      st_rd.addr[Q00] = ADDR_W'(row0_base + RA_W'(s3_x0_ff));
      st_rd.addr[Q10] = ADDR_W'(row0_base + RA_W'(s3_x1_ff));
      st_rd.addr[Q01] = ADDR_W'(row1_base + RA_W'(s3_x0_ff));
      st_rd.addr[Q11] = ADDR_W'(row1_base + RA_W'(s3_x1_ff));
   end

   bts_texel_store u_store (
      .clock (clock),
      .wr    (st_wr),
      .rd    (st_rd),
      .quad  (quad)
   );

   // Write items end here; only samples go on.
   assign s4_vld_in = s3_vld_ff && s3_smp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en4) begin
         s4_vld_ff <= s4_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en4 && s4_vld_in) begin
         s4_tx_ff <= s3_tx_ff;
         s4_ty_ff <= s3_ty_ff;
      end
   end

   // Stage 5: replicate missing channels and blend along each row.
   logic [CH_COUNT-1:0][H_W-1:0] s5_h0_ff, s5_h1_ff, s5_h0_in, s5_h1_in;
   logic [WGT_W-1:0]             s5_ty_ff;
   logic [WGT_W-1:0]             wx_left;

   always_comb begin
      wx_left = ONE_FX - s4_tx_ff;
      for (int c = 0; c < CH_COUNT; c++) begin
         s5_h0_in[c] = H_W'(
            P_W'(texel_chan(quad[Q00], 2'(c), chan_cnt_ff)) * P_W'(wx_left) +
            P_W'(texel_chan(quad[Q10], 2'(c), chan_cnt_ff)) * P_W'(s4_tx_ff));
         s5_h1_in[c] = H_W'(
            P_W'(texel_chan(quad[Q01], 2'(c), chan_cnt_ff)) * P_W'(wx_left) +
            P_W'(texel_chan(quad[Q11], 2'(c), chan_cnt_ff)) * P_W'(s4_tx_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en5) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5 && s4_vld_ff) begin
         s5_h0_ff <= s5_h0_in;
         s5_h1_ff <= s5_h1_in;
         s5_ty_ff <= s4_ty_ff;
      end
   end

   // Stage 6: blend the rows and truncate (white for an empty texture); hold the response.
   logic [CH_COUNT-1:0][OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [WGT_W-1:0]               wy_top;
   logic [P_W-1:0]                 vsum;

   always_comb begin
      wy_top = ONE_FX - s5_ty_ff;
      vsum   = '0;
      for (int c = 0; c < CH_COUNT; c++) begin
         vsum = P_W'(s5_h0_ff[c]) * P_W'(wy_top) + P_W'(s5_h1_ff[c]) * P_W'(s5_ty_ff);
         rsp_col_in[c] = tex_empty ? WHITE_FX : vsum[FRAC_BITS +: OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en6) begin
         rsp_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6 && s5_vld_ff) begin
         rsp_col_ff <= rsp_col_in;
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.red_out   = rsp_col_ff[CH_RED];
   assign rsp_ch.green_out = rsp_col_ff[CH_GREEN];
   assign rsp_ch.blue_out  = rsp_col_ff[CH_BLUE];

   // A texel write must never turn into a response.
   `BTS_ASSERT_NXT(a_write_ends, clock, reset, en4 && s3_vld_ff && !s3_smp_ff, !s4_vld_ff)
   // The right-hand neighbor is the clamped column itself or the next one.
   `BTS_ASSERT_IMP(a_col_pair, clock, reset, s3_vld_ff && s3_smp_ff,
                   (s3_x1_ff == s3_x0_ff) || (s3_x1_ff == s3_x0_ff + 8'd1))
   // Blend weights never exceed one.
   `BTS_ASSERT_IMP(a_wgt_range, clock, reset, s4_vld_ff,
                   (s4_tx_ff <= ONE_FX) && (s4_ty_ff <= ONE_FX))

endmodule

`default_nettype wire

FILE: tb/bilinear_color_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the texture sampler,
// predicts the filtered color of every sample and compares it with the response.
module bilinear_color_checker (
   input  logic                          clock,
   input  logic                          reset,
   bts_req_if                            req_mon,
   bts_rsp_if                            rsp_mon,
   input  logic                          csr_we,
   input  logic [bts_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [bts_pkg::DIM_W-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            colors_pending
);
   import bts_pkg::*;

   // One color: index 0 is red, 1 is green, 2 is blue, each a byte with 16 fraction bits.
   typedef logic [CH_COUNT-1:0][OUT_W-1:0] rgb_fx_type;

   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   logic [CNT_W-1:0]   chan_reg;
   logic [TEXEL_W-1:0] texel_mem [TEXEL_DEPTH];
   rgb_fx_type         expected_colors [$];
   string              chan_name [CH_COUNT] = '{"red", "green", "blue"};

   // Channels that the source image lacks repeat its first byte.
   function automatic logic [BYTE_W-1:0] channel_byte(input logic [TEXEL_W-1:0] t,
                                                      input int c);
      if (c == 0 || int'(chan_reg) > c) begin
         return t[c*BYTE_W +: BYTE_W];
      end
      return t[BYTE_W-1:0];
   endfunction

   // Filtered color at (u, v) from the current texture and register settings.
   function automatic rgb_fx_type bilinear_color(input logic [FIX_W-1:0] u,
                                                 input logic [FIX_W-1:0] v);
      longint unsigned one, w, h, sx, sy, fu, gv, x, y, x0, y0, x1, y1, tx, ty;
      longint unsigned near_row, far_row;
      logic [TEXEL_W-1:0] q00, q10, q01, q11;
      rgb_fx_type color;
      one = longint'(1) << FRAC_BITS;
      if (width_reg == 0 || height_reg == 0 || chan_reg == 0) begin
         return {CH_COUNT{WHITE_FX}};
      end

      // Oversized dimensions behave as the largest texture.
      w  = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
      h  = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
      sx = (w > 1) ? w - 1 : 1;
      sy = (h > 1) ? h - 1 : 1;

      // Only the fraction of each coordinate counts; v runs from the bottom row.
      fu = longint'(u[15:0]) << (FRAC_BITS - 16);
      gv = one - (longint'(v[15:0]) << (FRAC_BITS - 16));
      x  = fu * sx;
      y  = gv * sy;

      // Neighbor columns and rows are clamped at the last texel.
      x0 = x >> FRAC_BITS;
      if (x0 > w - 1) begin
         x0 = w - 1;
      end
      y0 = y >> FRAC_BITS;
      if (y0 > h - 1) begin
         y0 = h - 1;
      end
      x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
      y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;

      // The weights may reach 1.0 when a one-texel dimension is clamped.
      tx = x - (x0 << FRAC_BITS);
      ty = y - (y0 << FRAC_BITS);
      if (tx > one) begin
         tx = one;
      end
      if (ty > one) begin
         ty = one;
      end

      // Addresses wrap around the store.
      q00 = texel_mem[ADDR_W'(y0 * w + x0)];
      q10 = texel_mem[ADDR_W'(y0 * w + x1)];
      q01 = texel_mem[ADDR_W'(y1 * w + x0)];
      q11 = texel_mem[ADDR_W'(y1 * w + x1)];

      for (int c = 0; c < CH_COUNT; c++) begin
         near_row = longint'(channel_byte(q00, c)) * (one - tx)
                  + longint'(channel_byte(q10, c)) * tx;
         far_row  = longint'(channel_byte(q01, c)) * (one - tx)
                  + longint'(channel_byte(q11, c)) * tx;
         color[c] = OUT_W'((near_row * (one - ty) + far_row * ty) >> FRAC_BITS);
      end
      return color;
   endfunction

   // Track register writes and texel writes, queue predictions, check responses.
   always @(posedge clock) begin : monitor
      rgb_fx_type got;
      rgb_fx_type want;
      if (reset) begin
         width_reg  = '0;
         height_reg = '0;
         chan_reg   = '0;
         expected_colors.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_TEX_WIDTH: begin
                  width_reg = csr_wdata;
               end
               CSR_TEX_HEIGHT: begin
                  height_reg = csr_wdata;
               end
               CSR_CHANNEL_COUNT: begin
                  chan_reg = csr_wdata[CNT_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_WRITE) begin
               texel_mem[req_mon.texel_index] = {req_mon.byte_two, req_mon.byte_one,
                                                 req_mon.byte_zero};
            end else begin
               expected_colors.push_back(bilinear_color(req_mon.u_coord,
                                                        req_mon.v_coord));
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.blue_out, rsp_mon.green_out, rsp_mon.red_out};
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected color transfer, expected none, got %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = expected_colors.pop_front();
               for (int c = 0; c < CH_COUNT; c++) begin
                  if (got[c] !== want[c]) begin
                     $display("%0t: %s expected %06h, got %06h",
                              $time, chan_name[c], want[c], got[c]);
                     mismatch_count++;
                  end
               end
            end
         end
      end
      colors_pending = expected_colors.size();
   end

endmodule

FILE: tb/tb_bilinear_texture_sampler.sv
`timescale 1ns / 1ps

// Drives texel writes, samples and register settings into the sampler and
// gives the verdict from the checker's mismatch count.
module tb_bilinear_texture_sampler;
   import bts_pkg::*;

   localparam int ITEM_TARGET   = 1650;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 2000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [DIM_W-1:0]     csr_wdata;
   int                   mismatch_count;
   int                   colors_pending;

   // Stimulus view of the texture: geometry and which texels hold data.
   int tex_w;
   int tex_h;
   int tex_cc;
   bit texel_loaded [TEXEL_DEPTH];
   int items_sent;
   int quiet_items;

   bts_req_if req_ch ();
   bts_rsp_if rsp_ch ();

   bilinear_texture_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   bilinear_color_checker color_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_idx        (csr_idx),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .colors_pending (colors_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Present one request after a random gap and hold it until its transfer.
   task automatic push_request(input logic act, input logic [ADDR_W-1:0] idx,
                               input logic [TEXEL_W-1:0] texel,
                               input logic [FIX_W-1:0] u, input logic [FIX_W-1:0] v);
      int gap;
      int roll;
      gap = 0;
      if (quiet_items > 0) begin
         quiet_items--;
      end else begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            quiet_items = $urandom_range(10, 60);
         end else if (roll < 60) begin
            gap = 0;
         end else if (roll < 88) begin
            gap = $urandom_range(1, 3);
         end else if (roll < 98) begin
            gap = $urandom_range(4, 10);
         end else begin
            gap = $urandom_range(20, 40);
         end
      end
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.action      = act;
      req_ch.texel_index = idx;
      req_ch.byte_zero   = texel[7:0];
      req_ch.byte_one    = texel[15:8];
      req_ch.byte_two    = texel[23:16];
      req_ch.u_coord     = u;
      req_ch.v_coord     = v;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic load_texel(input logic [ADDR_W-1:0] idx, input logic [TEXEL_W-1:0] texel);
      push_request(ACT_WRITE, idx, texel, $urandom, $urandom);
      texel_loaded[idx] = 1'b1;
   endtask

   // Sample at (u, v), first filling any of the four neighbors that holds no data.
   task automatic sample_at(input logic [FIX_W-1:0] u, input logic [FIX_W-1:0] v);
      int w, h, sx, sy, x0, x1, y0, y1;
      logic [ADDR_W-1:0] taps [4];
      if (tex_w != 0 && tex_h != 0 && tex_cc != 0) begin
         w  = (tex_w > MAX_DIM) ? MAX_DIM : tex_w;
         h  = (tex_h > MAX_DIM) ? MAX_DIM : tex_h;
         sx = (w > 1) ? w - 1 : 1;
         sy = (h > 1) ? h - 1 : 1;
         x0 = (int'(u[15:0]) * sx) >> 16;
         y0 = ((65536 - int'(v[15:0])) * sy) >> 16;
         x0 = (x0 > w - 1) ? w - 1 : x0;
         y0 = (y0 > h - 1) ? h - 1 : y0;
         x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
         y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
         taps = '{ADDR_W'(y0 * w + x0), ADDR_W'(y0 * w + x1),
                  ADDR_W'(y1 * w + x0), ADDR_W'(y1 * w + x1)};
         foreach (taps[k]) begin
            if (!texel_loaded[taps[k]]) begin
               load_texel(taps[k], TEXEL_W'($urandom));
            end
         end
      end
      push_request(ACT_SAMPLE, ADDR_W'($urandom), TEXEL_W'($urandom), u, v);
   endtask

   // Wait until every color has come back and any write in flight has landed.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (colors_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_texture(input int w, input int h, input int cc);
      wait_idle();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_idx   = CSR_TEX_WIDTH;
      csr_wdata = DIM_W'(w);
      @(negedge clock);
      csr_idx   = CSR_TEX_HEIGHT;
      csr_wdata = DIM_W'(h);
      @(negedge clock);
      csr_idx   = CSR_CHANNEL_COUNT;
      csr_wdata = DIM_W'(cc);
      @(negedge clock);
      csr_we    = 1'b0;
      tex_w  = w;
      tex_h  = h;
      tex_cc = cc;
   endtask

   // Mostly small dimensions, with empty, full-size and oversized ones now and then.
   function automatic int random_dim();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) begin
         return 0;
      end else if (roll < 10) begin
         return MAX_DIM;
      end else if (roll < 14) begin
         return $urandom_range(MAX_DIM + 1, 511);
      end else if (roll < 30) begin
         return $urandom_range(9, 64);
      end
      return $urandom_range(1, 8);
   endfunction

   // Random coordinate whose fraction often sits on a texel or at an end of the range.
   function automatic logic [FIX_W-1:0] random_coord();
      logic [FIX_W-1:0] c;
      c = $urandom;
      case ($urandom_range(11))
         0: c[15:0] = 16'h0000;
         1: c[15:0] = 16'hFFFF;
         2: c[15:0] = 16'h8000;
         3: c[15:0] = 16'h0001;
         default: begin
         end
      endcase
      return c;
   endfunction

   // Response back-pressure: short and long stalls, and stretches with none.
   initial begin : rsp_backpressure
      int hold;
      int quiet;
      int roll;
      rsp_ch.ready = 1'b0;
      hold  = 0;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
            if (quiet > 0) begin
               quiet--;
            end else begin
               roll = $urandom_range(99);
               if (roll < 2) begin
                  quiet = $urandom_range(20, 100);
               end else if (roll < 20) begin
                  hold = $urandom_range(1, 3);
               end else if (roll < 24) begin
                  hold = $urandom_range(4, 12);
               end else if (roll == 24) begin
                  hold = $urandom_range(30, 60);
               end
            end
         end
      end
   end

   // End the run when no transfer has happened for too long.
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase_len;
      int region;
      int roll;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_idx            = CSR_TEX_WIDTH;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_WRITE;
      req_ch.texel_index = '0;
      req_ch.byte_zero   = '0;
      req_ch.byte_one    = '0;
      req_ch.byte_two    = '0;
      req_ch.u_coord     = '0;
      req_ch.v_coord     = '0;
      tex_w       = 0;
      tex_h       = 0;
      tex_cc      = 0;
      items_sent  = 0;
      quiet_items = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Empty texture out of reset gives white.
      sample_at(32'h0000_0000, 32'h0000_0000);
      sample_at(32'h7FFF_FFFF, 32'h8000_0000);

      // Small full-color texture: extreme bytes, index and coordinates.
      set_texture(2, 2, 3);
      load_texel(16'hFFFF, 24'hFFFFFF);
      load_texel(16'h0000, 24'h000000);
      sample_at(32'h0000_0000, 32'h0000_0000);
      sample_at(32'h0000_FFFF, 32'h0000_FFFF);
      sample_at(32'h0000_8000, 32'h0000_8000);
      sample_at(32'h8000_0000, 32'h7FFF_FFFF);
      sample_at(32'hFFFF_FFFF, 32'h0001_0000);

      // Single texel with one channel: the vertical weight reaches one.
      set_texture(1, 1, 1);
      sample_at(32'h0000_1234, 32'h0000_0000);

      // Oversized dimensions and a channel count above four.
      set_texture(511, 300, 7);
      sample_at(32'h0000_FFFF, 32'h0000_0001);
      sample_at(32'h0000_0000, 32'h0000_0000);

      // Zero height, then zero channels, give white.
      set_texture(5, 0, 3);
      sample_at(random_coord(), random_coord());
      set_texture(5, 5, 0);
      sample_at(random_coord(), random_coord());

      // Random phases: a fresh texture setting, then a mix of writes and samples.
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(99);
         set_texture(random_dim(), random_dim(),
                     (roll < 5) ? 0 : (roll < 20) ? $urandom_range(4, 7)
                                                 : $urandom_range(1, 3));
         region = ((tex_w > MAX_DIM) ? MAX_DIM : tex_w)
                * ((tex_h > MAX_DIM) ? MAX_DIM : tex_h);
         phase_len = (region > 4096) ? $urandom_range(10, 40) : $urandom_range(20, 120);
         for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
               sample_at(random_coord(), random_coord());
            end else if (roll < 90 && region > 0) begin
               load_texel(ADDR_W'($urandom_range(region - 1)), TEXEL_W'($urandom));
            end else begin
               load_texel(ADDR_W'($urandom), TEXEL_W'($urandom));
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: bilinear_texture_sampler.f
+incdir+hw/rtl
hw/rtl/bts_pkg.sv
hw/rtl/bts_req_if.sv
hw/rtl/bts_rsp_if.sv
hw/rtl/bts_texel_store.sv
hw/rtl/bilinear_texture_sampler.sv
tb/bilinear_color_checker.sv
tb/tb_bilinear_texture_sampler.sv
